>>> hdl/lss_pkg.sv
// ----------------------------------------------------------------------------
// LIFO stack package
// Shared constants, action and condition codes, and the command and status
// groups that pass between the stack controller and its datapath.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int DEPTH         = 64;
  localparam int ADDR_W        = $clog2(DEPTH);
  localparam int FILL_W        = $clog2(DEPTH + 1);
  localparam int WORD_W        = 32;
  localparam int POS_W         = 6;
  localparam int PCT_W         = 7;
  localparam int PERCENT_SCALE = 100;
  localparam int PCT_PROD_W    = 14;
  localparam int ACTION_W      = 3;
  localparam int COND_W        = 2;
  localparam int IN_DATA_W     = 32;
  localparam int OUT_FIELDS_W  = WORD_W + POS_W + FILL_W + PCT_W;
  localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [ACTION_W-1:0] {
    A_PUSH   = 3'd0,
    A_POP    = 3'd1,
    A_PEEK   = 3'd2,
    A_CLEAR  = 3'd3,
    A_SEARCH = 3'd4,
    A_STATUS = 3'd5
  } action_e;

  typedef enum logic [COND_W-1:0] {
    C_OK       = 2'd0,
    C_FULL     = 2'd1,
    C_EMPTY    = 2'd2,
    C_NOTFOUND = 2'd3
  } cond_e;

  // Source of the value field of a result.
  typedef enum logic [1:0] {
    VS_ZERO,
    VS_RAM,
    VS_OPND
  } val_sel_e;

  // Source of the position field of a result.
  typedef enum logic [1:0] {
    PS_ZERO,
    PS_FILL,
    PS_SCAN,
    PS_PEND
  } pos_sel_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic     in_ready;
    logic     push_wr;
    logic     fill_inc;
    logic     fill_dec;
    logic     fill_clr;
    logic     rd_top;
    logic     rd_next;
    logic     scan_load;
    logic     pend_set;
    logic     pend_clr;
    logic     out_load;
    cond_e    out_cond;
    val_sel_e out_val;
    pos_sel_e out_pos;
    logic     out_last;
  } cmd_t;

  typedef struct packed {
    logic    in_valid;
    action_e action;
    logic    fill_zero;
    logic    fill_full;
    logic    match;
    logic    scan_zero;
    logic    pend_valid;
    logic    out_free;
  } status_t;

endpackage

>>> hdl/lifo_stack_with_search_top.sv
// ----------------------------------------------------------------------------
// LIFO stack with search
// Push, pop, peek, clear, search and status requests on a 64-word stack.
// Push, clear and status are answered straight from the idle state; pop and
// peek pass through a read state, since the word comes from the registered
// read port of the word store. Search reads the store once per slot walked.
// A result is registered in the output register when it is formed.
// Reset empties the stack at once; stored words are not cleared.
// ----------------------------------------------------------------------------
module lifo_stack_with_search_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Request channel. tdata: operand_value [31:0]. tuser: action [2:0].
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [lss_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic [lss_pkg::ACTION_W-1:0]   s_axis_tuser_i,
  // Result channel. tdata: result_value [31:0], position [37:32],
  // fill_count [44:38], percent_used [51:45], zero [55:52].
  // tuser: condition [1:0]. tlast: final result of a request.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [lss_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic [lss_pkg::COND_W-1:0]     m_axis_tuser_o,
  output logic                           m_axis_tlast_o
);
  import lss_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // The controller decodes each request and walks the search; the datapath
  // holds the store, the fill level and the result register. A request is
  // taken only when the controller is idle and the result register is free
  // or draining in the same cycle.
  assign s_axis_tready_o = cmd.in_ready;

  lss_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  // During a search each match is held back until the next match or the end
  // of the walk, so that the final match can carry tlast.
  lss_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

endmodule

>>> hdl/lss_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enable-held read.
// ----------------------------------------------------------------------------
module lss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/lss_ctrl.sv
// ----------------------------------------------------------------------------
// LIFO stack controller
// Decodes each request and sequences reads and the top-down search walk.
// ----------------------------------------------------------------------------
module lss_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lss_pkg::status_t sts_i,
  output lss_pkg::cmd_t    cmd_o
);
  import lss_pkg::*;

  state_e state_q, state_d;
  logic   pop_q, pop_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pop_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pop_q   <= pop_d;
    end
  end

  always_comb begin
    state_d = state_q;
    pop_d   = pop_q;
    cmd_o   = '0;
    cmd_o.out_cond = C_OK;
    cmd_o.out_val  = VS_ZERO;
    cmd_o.out_pos  = PS_ZERO;
    accept  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = sts_i.out_free;
        accept         = sts_i.in_valid && sts_i.out_free;
        if (accept) begin
          case (sts_i.action)
            A_PUSH: begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_last = 1'b1;
              if (sts_i.fill_full) begin
                cmd_o.out_cond = C_FULL;
              end else begin
                cmd_o.push_wr  = 1'b1;
                cmd_o.fill_inc = 1'b1;
                cmd_o.out_pos  = PS_FILL;
              end
            end
            A_POP, A_PEEK: begin
              if (sts_i.fill_zero) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_last = 1'b1;
                cmd_o.out_cond = C_EMPTY;
              end else begin
                cmd_o.rd_top    = 1'b1;
                cmd_o.scan_load = 1'b1;
                pop_d           = (sts_i.action == A_POP);
                state_d         = ST_READ;
              end
            end
            A_CLEAR: begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_last = 1'b1;
              if (sts_i.fill_zero) begin
                cmd_o.out_cond = C_EMPTY;
              end else begin
                cmd_o.fill_clr = 1'b1;
              end
            end
            A_SEARCH: begin
              if (sts_i.fill_zero) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_last = 1'b1;
                cmd_o.out_cond = C_EMPTY;
              end else begin
                cmd_o.rd_top    = 1'b1;
                cmd_o.scan_load = 1'b1;
                cmd_o.pend_clr  = 1'b1;
                state_d         = ST_SCAN;
              end
            end
            A_STATUS: begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_last = 1'b1;
            end
            default: begin
              // Undefined action codes are dropped without a result.
            end
          endcase
        end
      end

      ST_READ: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          cmd_o.out_val  = VS_RAM;
          cmd_o.out_pos  = PS_SCAN;
          cmd_o.fill_dec = pop_q;
          state_d        = ST_IDLE;
        end
      end

      ST_SCAN: begin
        // A new match pushes the previous one out with last clear; hold the
        // walk when that result cannot be stored.
        if (!(sts_i.match && sts_i.pend_valid && !sts_i.out_free)) begin
          if (sts_i.match) begin
            cmd_o.pend_set = 1'b1;
            if (sts_i.pend_valid) begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_val  = VS_OPND;
              cmd_o.out_pos  = PS_PEND;
            end
          end
          if (sts_i.scan_zero) begin
            state_d = ST_DONE;
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end
      end

      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          if (sts_i.pend_valid) begin
            cmd_o.out_val = VS_OPND;
            cmd_o.out_pos = PS_PEND;
          end else begin
            cmd_o.out_cond = C_NOTFOUND;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/lss_dp.sv
// ----------------------------------------------------------------------------
// LIFO stack datapath
// Word store, fill level, search cursor, pending match and result register.
// ----------------------------------------------------------------------------
module lss_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lss_pkg::cmd_t                    cmd_i,
  output lss_pkg::status_t                 sts_o,
  input  logic                             s_axis_tvalid_i,
  input  logic [lss_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  input  logic [lss_pkg::ACTION_W-1:0]     s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [lss_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  output logic [lss_pkg::COND_W-1:0]       m_axis_tuser_o,
  output logic                             m_axis_tlast_o
);
  import lss_pkg::*;

  logic [FILL_W-1:0]     fill_q, fill_d;
  logic [ADDR_W-1:0]     scan_q;
  logic [ADDR_W-1:0]     top_slot;
  logic                  pend_q;
  logic [ADDR_W-1:0]     pend_pos_q;
  logic [WORD_W-1:0]     op_q;
  logic [WORD_W-1:0]     rdata;
  logic [ADDR_W-1:0]     raddr;
  logic                  accept;
  logic                  out_free;
  logic [PCT_PROD_W-1:0] pct_prod;

  logic                  out_valid_q;
  logic [COND_W-1:0]     out_cond_q;
  logic [WORD_W-1:0]     out_val_q;
  logic [POS_W-1:0]      out_pos_q;
  logic [FILL_W-1:0]     out_fill_q;
  logic [PCT_W-1:0]      out_pct_q;
  logic                  out_last_q;

  assign accept   = s_axis_tvalid_i && cmd_i.in_ready;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign top_slot = ADDR_W'(fill_q - FILL_W'(1));
  assign raddr    = cmd_i.rd_top ? top_slot : ADDR_W'(scan_q - ADDR_W'(1));

  lss_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push_wr),
    .waddr_i(fill_q[ADDR_W-1:0]),
    .wdata_i(s_axis_tdata_i[WORD_W-1:0]),
    .re_i   (cmd_i.rd_top || cmd_i.rd_next),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.fill_clr) begin
      fill_d = '0;
    end else if (cmd_i.fill_inc) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (cmd_i.fill_dec) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  // The depth is a power of two, so the divide reduces to a shift.
  assign pct_prod = PCT_PROD_W'(fill_d) * PCT_PROD_W'(PERCENT_SCALE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (cmd_i.pend_clr) begin
        pend_q <= 1'b0;
      end else if (cmd_i.pend_set) begin
        pend_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= s_axis_tdata_i[WORD_W-1:0];
    end
    if (cmd_i.scan_load) begin
      scan_q <= top_slot;
    end else if (cmd_i.rd_next) begin
      scan_q <= scan_q - ADDR_W'(1);
    end
    if (cmd_i.pend_set) begin
      pend_pos_q <= scan_q;
    end
    if (cmd_i.out_load) begin
      out_cond_q <= cmd_i.out_cond;
      out_last_q <= cmd_i.out_last;
      out_fill_q <= fill_d;
      out_pct_q  <= PCT_W'(pct_prod / PCT_PROD_W'(DEPTH));
      case (cmd_i.out_val)
        VS_RAM:  out_val_q <= rdata;
        VS_OPND: out_val_q <= op_q;
        default: out_val_q <= '0;
      endcase
      case (cmd_i.out_pos)
        PS_FILL: out_pos_q <= POS_W'(fill_q[ADDR_W-1:0]);
        PS_SCAN: out_pos_q <= POS_W'(scan_q);
        PS_PEND: out_pos_q <= POS_W'(pend_pos_q);
        default: out_pos_q <= '0;
      endcase
    end
  end

  always_comb begin
    sts_o.in_valid   = s_axis_tvalid_i;
    sts_o.action     = action_e'(s_axis_tuser_i);
    sts_o.fill_zero  = (fill_q == '0);
    sts_o.fill_full  = (fill_q == FILL_W'(DEPTH));
    sts_o.match      = (rdata == op_q);
    sts_o.scan_zero  = (scan_q == '0);
    sts_o.pend_valid = pend_q;
    sts_o.out_free   = out_free;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_cond_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = OUT_DATA_W'({out_pct_q, out_fill_q, out_pos_q, out_val_q});

endmodule
